### src/binary_cross_morphology_edge_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef BINARY_CROSS_MORPHOLOGY_EDGE_MACROS_SVH
`define BINARY_CROSS_MORPHOLOGY_EDGE_MACROS_SVH

// Holds in the cycle after any cycle in which reset is high.
`define BCME_CHK_RESET(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("bcme reset check failed");

// Holds in the same cycle as the condition, outside reset.
`define BCME_CHK_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcme check failed");

// Holds in the cycle after the condition, outside reset.
`define BCME_CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcme sequence check failed");

`endif

### src/bcme_pkg.sv
package bcme_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W      = 8;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic [PIX_W-1:0]   THRESHOLD_RESET = 8'd127;
  localparam logic [IMG_W_W-1:0] WIDTH_RESET     = 12'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET    = 13'd480;

  localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic bin;
    logic left_ok;
    logic left2_ok;
    logic right_ok;
    logic row_ge1;
    logic row_ge2;
    logic last_row;
    logic last_col;
  } item_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] binary_pixel;
    logic [PIX_W-1:0] dilated_pixel;
    logic [PIX_W-1:0] eroded_pixel;
    logic [PIX_W-1:0] edge_pixel;
    logic             last_of_run;
    logic             end_of_frame;
  } res_t;

endpackage

### src/bcme_fifo.sv
module bcme_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] din,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] ent [DEPTH];
  logic [AW-1:0]     wptr;
  logic [AW-1:0]     rptr;
  logic [NW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = ent[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wptr] <= din;
    end
  end

endmodule

### src/bcme_front.sv
module bcme_front #(
  parameter int MAX_WIDTH  = bcme_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bcme_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bcme_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [bcme_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               push,
  input  logic                               q_full,
  input  logic [bcme_pkg::PIX_W-1:0]         gray_pixel,
  output logic                               q_push,
  output logic [$clog2(MAX_WIDTH)-1:0]       q_col,
  output bcme_pkg::item_flags_t              q_flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int WX = (EW > bcme_pkg::IMG_W_W) ? EW : bcme_pkg::IMG_W_W;
  localparam int HX = (HW > bcme_pkg::IMG_H_W) ? HW : bcme_pkg::IMG_H_W;

  logic [bcme_pkg::PIX_W-1:0]   threshold;
  logic [bcme_pkg::IMG_W_W-1:0] img_width;
  logic [bcme_pkg::IMG_H_W-1:0] img_height;
  logic [CW-1:0]                col_cnt;
  logic [RW-1:0]                row_cnt;

  logic [WX-1:0] w_ext;
  logic [HX-1:0] h_ext;
  logic [EW-1:0] wlim;
  logic [EW-1:0] wlast;
  logic [HW-1:0] hlim;
  logic [HW-1:0] hlast;
  logic          wrap;
  logic [CW-1:0] col_cur;
  logic [HW-1:0] row_inc;
  logic [RW-1:0] row_cur;
  logic          last_col;
  logic          last_row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic          accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= bcme_pkg::THRESHOLD_RESET;
      img_width  <= bcme_pkg::WIDTH_RESET;
      img_height <= bcme_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bcme_pkg::REG_THRESHOLD: threshold  <= cfg_data[bcme_pkg::PIX_W-1:0];
        bcme_pkg::REG_WIDTH:     img_width  <= cfg_data[bcme_pkg::IMG_W_W-1:0];
        bcme_pkg::REG_HEIGHT:    img_height <= cfg_data[bcme_pkg::IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext = WX'(img_width);
    h_ext = HX'(img_height);
    if (img_width == '0) begin
      wlim = EW'(1);
    end else if (w_ext > WX'(MAX_WIDTH)) begin
      wlim = EW'(MAX_WIDTH);
    end else begin
      wlim = EW'(img_width);
    end
    if (img_height == '0) begin
      hlim = HW'(1);
    end else if (h_ext > HX'(MAX_HEIGHT)) begin
      hlim = HW'(MAX_HEIGHT);
    end else begin
      hlim = HW'(img_height);
    end
    wlast = wlim - EW'(1);
    hlast = hlim - HW'(1);

    wrap    = (EW'(col_cnt) >= wlim);
    col_cur = wrap ? '0 : col_cnt;
    row_inc = wrap ? HW'(row_cnt) + HW'(1) : HW'(row_cnt);
    row_cur = (row_inc >= hlim) ? '0 : RW'(row_inc);

    last_col = (EW'(col_cur) == wlast);
    last_row = (HW'(row_cur) == hlast);

    col_next = last_col ? '0 : col_cur + CW'(1);
    if (last_col) begin
      row_next = last_row ? '0 : row_cur + RW'(1);
    end else begin
      row_next = row_cur;
    end

    q_flags.bin      = (gray_pixel < threshold);
    q_flags.left_ok  = (col_cur != '0);
    q_flags.left2_ok = (col_cur > CW'(1));
    q_flags.right_ok = !last_col;
    q_flags.row_ge1  = (row_cur != '0);
    q_flags.row_ge2  = (row_cur > RW'(1));
    q_flags.last_row = last_row;
    q_flags.last_col = last_col;
  end

  assign accept = push && !q_full;
  assign q_push = accept;
  assign q_col  = col_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      col_cnt <= col_next;
      row_cnt <= row_next;
    end
  end

endmodule

### src/bcme_back.sv
module bcme_back #(
  parameter int MAX_WIDTH = bcme_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  input  bcme_pkg::item_flags_t        q_flags,
  output logic                         q_pop,
  input  logic                         r_full,
  output logic                         r_push,
  output bcme_pkg::res_t               r_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int IDX_ABOVE  = 0;
  localparam int IDX_BEHIND = 1;
  localparam int IDX_CORNER = 2;

  typedef enum logic [1:0] {
    K_ABOVE,
    K_BEHIND,
    K_CORNER,
    K_NONE
  } kind_t;

  logic upper_mem [MAX_WIDTH];
  logic mid_mem   [MAX_WIDTH];

  logic                  busy;
  logic [2:0]            sent;
  logic [EW-1:0]         fill;
  logic [CW-1:0]         item_col;
  bcme_pkg::item_flags_t item_flags;
  logic                  rd_u;
  logic                  rd_m;
  logic                  rd_r;
  logic                  vc;
  logic                  vr;
  logic                  byc;
  logic                  byr;
  logic                  byp_u;
  logic                  byp_m;
  logic                  last_up;
  logic [1:0]            win;

  logic [CW-1:0] col_nx;
  logic          load;
  logic          done;
  logic          wr_en;
  logic          cur_u;
  logic          cur_m;
  logic          m_right;
  logic          w0;
  logic          w1;
  logic [2:0]    need;
  logic [2:0]    pend;
  logic [2:0]    sel;
  kind_t         kind;
  logic          last;
  logic          centre;
  logic [3:0]    nb_en;
  logic [3:0]    nb_val;
  logic          eof;
  logic          dil;
  logic          ero;

  assign col_nx = q_flags.right_ok ? q_col + CW'(1) : q_col;

  assign cur_u   = byc ? byp_u : (vc & rd_u);
  assign cur_m   = byc ? byp_m : (vc & rd_m);
  assign m_right = byr ? byp_m : (vr & rd_r);
  assign w0      = item_flags.left_ok & win[0];
  assign w1      = item_flags.left_ok & win[1];

  always_comb begin
    need[IDX_ABOVE]  = item_flags.row_ge1;
    need[IDX_BEHIND] = item_flags.last_row && item_flags.left_ok;
    need[IDX_CORNER] = item_flags.last_row && item_flags.last_col;
    pend = need & ~sent;
    if (pend[IDX_ABOVE]) begin
      kind = K_ABOVE;
    end else if (pend[IDX_BEHIND]) begin
      kind = K_BEHIND;
    end else if (pend[IDX_CORNER]) begin
      kind = K_CORNER;
    end else begin
      kind = K_NONE;
    end

    sel    = '0;
    centre = 1'b0;
    nb_en  = '0;
    nb_val = '0;
    eof    = 1'b0;
    case (kind)
      K_ABOVE: begin
        sel[IDX_ABOVE] = 1'b1;
        centre = cur_m;
        nb_en  = {1'b1, item_flags.row_ge2, item_flags.right_ok, item_flags.left_ok};
        nb_val = {item_flags.bin, cur_u, m_right, last_up};
      end
      K_BEHIND: begin
        sel[IDX_BEHIND] = 1'b1;
        centre = w0;
        nb_en  = {1'b0, item_flags.row_ge1, 1'b1, item_flags.left2_ok};
        nb_val = {1'b0, last_up, item_flags.bin, w1};
      end
      K_CORNER: begin
        sel[IDX_CORNER] = 1'b1;
        centre = item_flags.bin;
        nb_en  = {1'b0, item_flags.row_ge1, 1'b0, item_flags.left_ok};
        nb_val = {1'b0, cur_m, 1'b0, w0};
        eof    = 1'b1;
      end
      default: ;
    endcase

    last = ((pend & ~sel) == '0);
    dil  = centre | (|(nb_en & nb_val));
    ero  = centre & (&(~nb_en | nb_val));

    r_data.binary_pixel  = centre ? bcme_pkg::PIX_ON : bcme_pkg::PIX_OFF;
    r_data.dilated_pixel = dil ? bcme_pkg::PIX_ON : bcme_pkg::PIX_OFF;
    r_data.eroded_pixel  = ero ? bcme_pkg::PIX_ON : bcme_pkg::PIX_OFF;
    r_data.edge_pixel    = (centre && !ero) ? bcme_pkg::PIX_ON : bcme_pkg::PIX_OFF;
    r_data.last_of_run   = last;
    r_data.end_of_frame  = eof;
  end

  assign r_push = busy && (pend != '0) && !r_full;
  assign done   = busy && ((pend == '0) || (r_push && last));
  assign wr_en  = done;
  assign load   = !q_empty && (!busy || done);
  assign q_pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sent <= '0;
      fill <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (load || done) begin
        sent <= '0;
      end else if (r_push) begin
        sent <= sent | sel;
      end
      if (wr_en && (EW'(item_col) == fill)) begin
        fill <= fill + EW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[item_col] <= cur_m;
      mid_mem[item_col]   <= item_flags.bin;
    end
    if (load) begin
      rd_u <= upper_mem[q_col];
      rd_m <= mid_mem[q_col];
      rd_r <= mid_mem[col_nx];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_col   <= q_col;
      item_flags <= q_flags;
      vc         <= (EW'(q_col) < fill);
      vr         <= (EW'(col_nx) < fill);
      byc        <= wr_en && (item_col == q_col);
      byr        <= wr_en && (item_col == col_nx);
      byp_u      <= cur_m;
      byp_m      <= item_flags.bin;
    end
    if (done) begin
      last_up <= cur_m;
      win     <= {w0, item_flags.bin};
    end
  end

endmodule

### src/binary_cross_morphology_edge.sv
// Binary cross morphology with edge output for a raster-order grey pixel stream.
// Input side: offer gray_pixel with push; the item is taken when push is high
// and full is low. Result side: while empty is low the oldest result sits on
// the result ports and is taken when pop is high. Each result carries the
// thresholded, dilated, eroded and edge pixels of one position, one row behind
// the input; during the last row the pending row and the last row are flushed.
// last_of_run marks the final result caused by an input item and end_of_frame
// the result for the frame's last pixel. Configuration is written through
// cfg_valid, cfg_index and cfg_data, which are always ready.
// An item goes from the input queue to the result stage and its results to the
// output queue. One item is taken per cycle while full is low; items of the
// last row that cause two or three results hold the result stage until all are
// pushed through its single result port. Two line stores of one bit per column
// are kept in memory. Reset restores the default registers, empties both queues
// and marks the line stores as unwritten, so they read as zero with no clearing
// pass. When the receiver stalls, results collect in the output queue and items
// then in the input queue, after which full is raised.
module binary_cross_morphology_edge #(
  parameter int MAX_WIDTH  = bcme_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bcme_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [bcme_pkg::PIX_W-1:0]      gray_pixel,
  output logic                            empty,
  input  logic                            pop,
  output logic [bcme_pkg::PIX_W-1:0]      binary_pixel,
  output logic [bcme_pkg::PIX_W-1:0]      dilated_pixel,
  output logic [bcme_pkg::PIX_W-1:0]      eroded_pixel,
  output logic [bcme_pkg::PIX_W-1:0]      edge_pixel,
  output logic                            last_of_run,
  output logic                            end_of_frame,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bcme_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [bcme_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int FW    = $bits(bcme_pkg::item_flags_t);
  localparam int MID_W = CW + FW;
  localparam int RES_W = $bits(bcme_pkg::res_t);

  logic                  f_push;
  logic [CW-1:0]         f_col;
  bcme_pkg::item_flags_t f_flags;
  logic [MID_W-1:0]      mid_din;
  logic [MID_W-1:0]      mid_dout;
  logic                  mid_empty;
  logic                  mid_pop;
  logic [CW-1:0]         b_col;
  bcme_pkg::item_flags_t b_flags;
  logic                  r_push;
  logic                  r_full;
  bcme_pkg::res_t        r_data;
  logic [RES_W-1:0]      out_dout;
  bcme_pkg::res_t        head;

  bcme_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .q_full     (full),
    .gray_pixel (gray_pixel),
    .q_push     (f_push),
    .q_col      (f_col),
    .q_flags    (f_flags)
  );

  assign mid_din = {f_col, f_flags};

  bcme_fifo #(
    .DATA_W (MID_W),
    .DEPTH  (bcme_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .full  (full),
    .din   (mid_din),
    .pop   (mid_pop),
    .empty (mid_empty),
    .dout  (mid_dout)
  );

  assign b_col   = mid_dout[MID_W-1 -: CW];
  assign b_flags = bcme_pkg::item_flags_t'(mid_dout[FW-1:0]);

  bcme_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (mid_empty),
    .q_col   (b_col),
    .q_flags (b_flags),
    .q_pop   (mid_pop),
    .r_full  (r_full),
    .r_push  (r_push),
    .r_data  (r_data)
  );

  bcme_fifo #(
    .DATA_W (RES_W),
    .DEPTH  (bcme_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .full  (r_full),
    .din   (r_data),
    .pop   (pop),
    .empty (empty),
    .dout  (out_dout)
  );

  assign head          = bcme_pkg::res_t'(out_dout);
  assign binary_pixel  = head.binary_pixel;
  assign dilated_pixel = head.dilated_pixel;
  assign eroded_pixel  = head.eroded_pixel;
  assign edge_pixel    = head.edge_pixel;
  assign last_of_run   = head.last_of_run;
  assign end_of_frame  = head.end_of_frame;

endmodule

### src/bcme_checker.sv
`include "binary_cross_morphology_edge_macros.svh"

module bcme_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [bcme_pkg::PIX_W-1:0] binary_pixel,
  input logic [bcme_pkg::PIX_W-1:0] dilated_pixel,
  input logic [bcme_pkg::PIX_W-1:0] eroded_pixel,
  input logic [bcme_pkg::PIX_W-1:0] edge_pixel,
  input logic                       last_of_run,
  input logic                       end_of_frame
);

  `BCME_CHK_RESET(a_queues_clear, clk, rst, empty && !full)
  `BCME_CHK_NOW(a_edge_rel, clk, rst, !empty, edge_pixel == (binary_pixel - eroded_pixel))
  `BCME_CHK_NOW(a_order, clk, rst, !empty, (eroded_pixel <= binary_pixel) && (binary_pixel <= dilated_pixel))
  `BCME_CHK_NOW(a_eof_last, clk, rst, !empty && end_of_frame, last_of_run)
  `BCME_CHK_NEXT(a_head_holds, clk, rst, !empty && !pop, !empty && $stable(binary_pixel) && $stable(last_of_run))

endmodule

bind binary_cross_morphology_edge bcme_checker u_bcme_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .binary_pixel  (binary_pixel),
  .dilated_pixel (dilated_pixel),
  .eroded_pixel  (eroded_pixel),
  .edge_pixel    (edge_pixel),
  .last_of_run   (last_of_run),
  .end_of_frame  (end_of_frame)
);
